// ===== design/sc2a_pkg.sv =====
`default_nettype none

package sc2a_pkg;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam int unsigned SC_TABLE_LEN   = 58;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam int unsigned CHAR_W = 7;

  typedef logic [CHAR_W-1:0] char_t;

  // One result item as it leaves the pipeline
  typedef struct packed {
    logic  overflow;
    logic  available;
    logic  char_valid;
    char_t char_out;
  } res_t;

  localparam char_t PLAIN_MAP [0:SC_TABLE_LEN-1] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam char_t UPPER_MAP [0:SC_TABLE_LEN-1] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Break codes and codes past the table translate to zero
  function automatic char_t sc_lookup(input logic [7:0] code, input logic shifted);
    char_t ch;
    ch = '0;
    if (!code[7] && (code < 8'(SC_TABLE_LEN))) begin
      ch = shifted ? UPPER_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/scancode_to_ascii_fifo_top.sv =====
`default_nettype none

// Set-1 keyboard scancode translator with a character queue. A transaction
// with s_tuser low carries a scancode in s_tdata: shift make/break codes set
// and clear the shift state, other make codes below 58 are translated through
// the US plain or shifted table and a nonzero character is queued; a push
// into a full queue drops the character and flags overflow. A transaction with
// s_tuser high pops one character, or returns char_valid low on an empty
// queue. Every input transaction yields exactly one result. One transaction is
// taken every clock cycle unless the output stalls; its result is registered
// together with the synchronous read of the character RAM and then again in the
// output buffer. The queue holds at most FIFO_DEPTH - 1 characters and its
// RAM needs no clearing after reset.
module scancode_to_ascii_fifo_top
  import sc2a_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] scancode
  input  wire logic        s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [6:0] char_out, [7] available, [8] overflow
  output logic             m_tuser    // [0] char_valid
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic          p1_valid;
  logic          p1_ready;
  res_t          p1_res;
  res_t          out_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  char_t         ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  char_t         ram_rdata;

  sc2a_ctrl #(
    .DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (s_tuser),
    .scancode  (s_tdata),
    .out_valid (p1_valid),
    .out_ready (p1_ready),
    .out_res   (p1_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sc2a_ram #(
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sc2a_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .in_ready  (p1_ready),
    .in_res    (p1_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {7'b0, out_res.overflow, out_res.available, out_res.char_out};
  assign m_tuser = out_res.char_valid;

  a_ovf_not_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.overflow && out_res.char_valid))
    else $error("overflow reported on a read result");

  a_ovf_means_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.overflow) |-> out_res.available)
    else $error("overflow reported while queue not full");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.char_valid) |-> (out_res.char_out != '0))
    else $error("zero character popped");

  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && p1_valid))
    else $error("input stalled with no pending result");

endmodule

`default_nettype wire

// ===== design/sc2a_ram.sv =====
`default_nettype none

module sc2a_ram
  import sc2a_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire char_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output char_t              rdata
);

  char_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sc2a_ctrl.sv =====
`default_nettype none

module sc2a_ctrl
  import sc2a_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          mode,
  input  wire logic [7:0]    scancode,
  output logic               out_valid,
  input  wire logic          out_ready,
  output res_t               out_res,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output char_t              ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  wire char_t         ram_rdata
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic          shift_held;
  logic          shift_held_next;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] rd_ptr_next;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] wr_ptr_next;
  logic          p1_valid;
  logic          p1_char_valid;
  logic          p1_available;
  logic          p1_overflow;

  logic          accept;
  logic          is_scan;
  logic          shift_set;
  logic          shift_clr;
  char_t         ch;
  logic          push_req;
  logic [AW-1:0] wr_inc;
  logic [AW-1:0] rd_inc;
  logic          full;
  logic          empty;
  logic          push;
  logic          pop;

  assign in_ready = !p1_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_scan   = (mode == MODE_SCAN);
  assign shift_set = (scancode == SC_LSHIFT_MAKE) || (scancode == SC_RSHIFT_MAKE);
  assign shift_clr = (scancode == SC_LSHIFT_BREAK) || (scancode == SC_RSHIFT_BREAK);
  assign ch        = sc_lookup(scancode, shift_held);
  assign push_req  = is_scan && !shift_set && !shift_clr && (ch != '0);

  assign wr_inc = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
  assign full   = (wr_inc == rd_ptr);
  assign empty  = (rd_ptr == wr_ptr);

  assign push = accept && push_req && !full;
  assign pop  = accept && !is_scan && !empty;

  always_comb begin
    shift_held_next = shift_held;
    if (accept && is_scan) begin
      if (shift_set) begin
        shift_held_next = 1'b1;
      end else if (shift_clr) begin
        shift_held_next = 1'b0;
      end
    end
  end

  assign wr_ptr_next = push ? wr_inc : wr_ptr;
  assign rd_ptr_next = pop ? rd_inc : rd_ptr;

  // Write and read never hit in the same cycle: one transaction per cycle
  assign ram_we    = push;
  assign ram_waddr = wr_ptr;
  assign ram_wdata = ch;
  assign ram_re    = pop;
  assign ram_raddr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      p1_valid   <= 1'b0;
    end else begin
      shift_held <= shift_held_next;
      rd_ptr     <= rd_ptr_next;
      wr_ptr     <= wr_ptr_next;
      if (accept) begin
        p1_valid <= 1'b1;
      end else if (out_ready) begin
        p1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_char_valid <= pop;
      p1_available  <= (rd_ptr_next != wr_ptr_next);
      p1_overflow   <= accept && push_req && full;
    end
  end

  assign out_valid           = p1_valid;
  assign out_res.char_out    = p1_char_valid ? ram_rdata : '0;
  assign out_res.char_valid  = p1_char_valid;
  assign out_res.available   = p1_available;
  assign out_res.overflow    = p1_overflow;

endmodule

`default_nettype wire

// ===== design/sc2a_skid.sv =====
`default_nettype none

module sc2a_skid
  import sc2a_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire res_t in_res,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic spare_valid;
  res_t spare;
  logic in_fire;
  logic out_free;

  assign in_ready = !spare_valid;
  assign in_fire  = in_valid && !spare_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_free) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      spare_valid <= 1'b1;
    end
  end

  // Park the incoming result in the spare slot while the output stalls
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= spare_valid ? spare : in_res;
    end else if (in_fire) begin
      spare <= in_res;
    end
  end

endmodule

`default_nettype wire
